// ----- hw/rtl/ping_pong_delay_hpf_defines.svh -----
// Assertion macros used by the checker file of the ping-pong delay block.
`ifndef PING_PONG_DELAY_HPF_DEFINES_SVH
`define PING_PONG_DELAY_HPF_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPDH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ping_pong_delay_hpf check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPDH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ping_pong_delay_hpf check failed");

`endif

// ----- hw/rtl/ppdh_pkg.sv -----
// Types and constants shared by the ping-pong delay block.
package ppdh_pkg;

  localparam int SampleW   = 24;
  localparam int GainW     = 17;
  localparam int CoefW     = 24;
  localparam int DlW       = 17;
  localparam int CfgW      = 24;
  localparam int OpW       = 25;
  localparam int ProdW     = 2 * OpW;
  localparam int AccW      = 52;
  localparam int CoefShift = 22;
  localparam int GainShift = 16;

  localparam logic [GainW-1:0] GainOne   = 17'd65536;
  localparam logic [DlW-1:0]   DlReset   = 17'd36000;
  localparam logic [GainW-1:0] WetReset  = 17'd32768;

  typedef enum logic [2:0] {
    CFG_DELAY_LENGTH = 3'd0,
    CFG_FEEDBACK     = 3'd1,
    CFG_WET_MIX      = 3'd2,
    CFG_START_LEFT   = 3'd3,
    CFG_FF_OUTER     = 3'd4,
    CFG_FF_MIDDLE    = 3'd5,
    CFG_FB_FIRST     = 3'd6,
    CFG_FB_SECOND    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] in_left;
    logic signed [SampleW-1:0] in_right;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_left;
    logic signed [SampleW-1:0] out_right;
  } out_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic add;
    logic coef_shift;
  } mac_ctl_t;

endpackage

// ----- hw/rtl/ppdh_mac.sv -----
// Shared multiply-accumulate unit with rounding, scaling shift and saturation.
module ppdh_mac (
  input  logic                              clk_i,
  input  ppdh_pkg::mac_ctl_t                ctl_i,
  input  logic signed [ppdh_pkg::OpW-1:0]   op_a_i,
  input  logic signed [ppdh_pkg::OpW-1:0]   op_b_i,
  output logic signed [ppdh_pkg::AccW-1:0]  shifted_o,
  output logic signed [ppdh_pkg::SampleW-1:0] sat_o
);
  import ppdh_pkg::*;

  localparam logic signed [AccW-1:0] SatHi = (AccW'(1) << (SampleW - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] SatLo = -SatHi - AccW'(1);
  localparam logic signed [AccW-1:0] RndCoef = AccW'(1) << (CoefShift - 1);
  localparam logic signed [AccW-1:0] RndGain = AccW'(1) << (GainShift - 1);

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [AccW-1:0]  sum;

  assign prod_ext = {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = ctl_i.coef_shift ? RndCoef : RndGain;
    end else if (ctl_i.add) begin
      acc_d = acc_q + prod_ext;
    end
  end

  // The product register only loads while terms are issued, so a result held at the
  // output keeps its value.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr || ctl_i.add) begin
      prod_q <= op_a_i * op_b_i;
    end
    acc_q <= acc_d;
  end

  // The last product is still in the product register when the result is taken.
  assign sum       = acc_q + prod_ext;
  assign shifted_o = ctl_i.coef_shift ? (sum >>> CoefShift) : (sum >>> GainShift);

  always_comb begin
    if (shifted_o > SatHi) begin
      sat_o = SatHi[SampleW-1:0];
    end else if (shifted_o < SatLo) begin
      sat_o = SatLo[SampleW-1:0];
    end else begin
      sat_o = shifted_o[SampleW-1:0];
    end
  end

endmodule

// ----- hw/rtl/ppdh_dmem.sv -----
// Single-port-write, single-port-read delay memory with registered read data.
module ppdh_dmem #(
  parameter  int Depth = 131072,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AddrW-1:0]                   waddr_i,
  input  logic signed [ppdh_pkg::SampleW-1:0] wdata_i,
  input  logic                               re_i,
  input  logic [AddrW-1:0]                   raddr_i,
  output logic signed [ppdh_pkg::SampleW-1:0] rdata_o
);
  import ppdh_pkg::*;

  logic signed [SampleW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/ping_pong_delay_hpf.sv -----
// The result item is registered at the output after the feedback, four biquad and two mix groups;
// no new item is taken until then. All 25 products go through one shared multiplier,
// and a result item that waits at the output holds the block until it is taken.
// Reset: histories clear and registers take their reset values; delay memory entries read as
// zero until written (write pointer and wrap flag, no clearing pass). Each delay_length write
// and reset stall the input while repeated subtraction reduces the length below DELAY_DEPTH.
module ping_pong_delay_hpf #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  ppdh_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ppdh_pkg::out_t               out_data_o,
  input  logic                         cfg_we_i,
  input  ppdh_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [ppdh_pkg::CfgW-1:0]    cfg_wdata_i
);
  import ppdh_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int CW = (AW + 1 > DlW) ? AW + 1 : DlW;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_FINISH} state_e;
  typedef enum logic [2:0] {
    GRP_FB, GRP_BQ0, GRP_BQ1, GRP_BQ2, GRP_BQ3, GRP_MIX_L, GRP_MIX_R
  } grp_e;

  typedef struct packed {
    logic signed [SampleW-1:0] x1;
    logic signed [SampleW-1:0] x2;
    logic signed [SampleW-1:0] y1;
    logic signed [SampleW-1:0] y2;
  } hist_t;

  function automatic logic [GainW-1:0] sat_gain(logic [GainW-1:0] v);
    return (v > GainOne) ? GainOne : v;
  endfunction

  function automatic logic signed [SampleW-1:0] sat_sum(logic signed [SampleW+2:0] v);
    logic signed [SampleW+2:0] hi;
    logic signed [SampleW+2:0] lo;
    hi = (SampleW+3)'((1 << (SampleW - 1)) - 1);
    lo = -hi - (SampleW+3)'(1);
    if (v > hi) return hi[SampleW-1:0];
    if (v < lo) return lo[SampleW-1:0];
    return v[SampleW-1:0];
  endfunction

  // Configuration registers.
  logic [GainW-1:0]        fb_gain_q, wet_q;
  logic                    start_left_q;
  logic signed [CoefW-1:0] c_outer_q, c_middle_q, c_first_q, c_second_q;
  logic [CW-1:0]           dl_rem_q;
  logic                    dl_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_gain_q    <= '0;
      wet_q        <= WetReset;
      start_left_q <= 1'b1;
      c_outer_q    <= '0;
      c_middle_q   <= '0;
      c_first_q    <= '0;
      c_second_q   <= '0;
      dl_rem_q     <= CW'(DlReset);
      dl_busy_q    <= 1'b1;
    end else begin
      if (dl_busy_q) begin
        if (dl_rem_q >= CW'(DELAY_DEPTH)) begin
          dl_rem_q <= dl_rem_q - CW'(DELAY_DEPTH);
        end else begin
          dl_busy_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DELAY_LENGTH: begin
            dl_rem_q  <= CW'(cfg_wdata_i[DlW-1:0]);
            dl_busy_q <= 1'b1;
          end
          CFG_FEEDBACK:   fb_gain_q    <= sat_gain(cfg_wdata_i[GainW-1:0]);
          CFG_WET_MIX:    wet_q        <= sat_gain(cfg_wdata_i[GainW-1:0]);
          CFG_START_LEFT: start_left_q <= cfg_wdata_i[0];
          CFG_FF_OUTER:   c_outer_q    <= cfg_wdata_i[CoefW-1:0];
          CFG_FF_MIDDLE:  c_middle_q   <= cfg_wdata_i[CoefW-1:0];
          CFG_FB_FIRST:   c_first_q    <= cfg_wdata_i[CoefW-1:0];
          CFG_FB_SECOND:  c_second_q   <= cfg_wdata_i[CoefW-1:0];
          default: ;
        endcase
      end
    end
  end

  state_e                    state_q;
  grp_e                      grp_q;
  logic [2:0]                term_q;
  logic [AW-1:0]             wp_q;
  logic                      full_q;
  logic                      echo_ok_q;
  logic                      out_valid_q;
  out_t                      out_q;
  hist_t                     hist_q [4];
  in_t                       in_q;
  logic signed [SampleW-1:0] x_q, fl_q, fr_q, mixl_q;

  logic                      in_acc;
  logic [AW-1:0]             d, rp;
  logic signed [SampleW-1:0] rd_l, rd_r, echo_l, echo_r;
  logic signed [SampleW:0]   in_sum;
  logic signed [SampleW-1:0] mono, fb_val, wr_l, wr_r;
  logic                      mem_we, is_bq, is_mix, last_term;
  logic [GainW-1:0]          dry;
  logic signed [OpW-1:0]     op_a, op_b;
  mac_ctl_t                  mac_ctl;
  logic signed [AccW-1:0]    mac_shifted;
  logic signed [SampleW-1:0] mac_sat;

  assign in_stall_o  = (state_q != ST_IDLE) || dl_busy_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign d = dl_rem_q[AW-1:0];
  always_comb begin
    if (wp_q >= d) begin
      rp = wp_q - d;
    end else begin
      rp = AW'((AW+1)'(wp_q) + (AW+1)'(DELAY_DEPTH) - (AW+1)'(d));
    end
  end

  // An entry that has not been written since reset reads as zero.
  assign echo_l = echo_ok_q ? rd_l : '0;
  assign echo_r = echo_ok_q ? rd_r : '0;

  assign in_sum = {in_q.in_left[SampleW-1], in_q.in_left}
                + {in_q.in_right[SampleW-1], in_q.in_right};
  assign mono   = in_sum[SampleW:1];
  assign fb_val = sat_sum({{3{mono[SampleW-1]}}, mono} + mac_shifted[SampleW+2:0]);
  assign wr_l   = start_left_q ? fb_val : echo_r;
  assign wr_r   = start_left_q ? echo_l : fb_val;
  assign mem_we = (state_q == ST_FINISH) && (grp_q == GRP_FB);

  ppdh_dmem #(.Depth(DELAY_DEPTH)) u_mem_l (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (wr_l),
    .re_i    (in_acc),
    .raddr_i (rp),
    .rdata_o (rd_l)
  );

  ppdh_dmem #(.Depth(DELAY_DEPTH)) u_mem_r (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (wr_r),
    .re_i    (in_acc),
    .raddr_i (rp),
    .rdata_o (rd_r)
  );

  assign is_bq  = grp_q inside {GRP_BQ0, GRP_BQ1, GRP_BQ2, GRP_BQ3};
  assign is_mix = grp_q inside {GRP_MIX_L, GRP_MIX_R};
  assign dry    = GainOne - wet_q;

  always_comb begin
    if (is_bq) begin
      last_term = (term_q == 3'd4);
    end else if (is_mix) begin
      last_term = (term_q == 3'd1);
    end else begin
      last_term = 1'b1;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (grp_q)
      GRP_FB: begin
        op_a = OpW'(start_left_q ? echo_r : echo_l);
        op_b = $signed({{(OpW - GainW){1'b0}}, fb_gain_q});
      end
      GRP_BQ0, GRP_BQ1, GRP_BQ2, GRP_BQ3: begin
        case (term_q)
          3'd0: begin op_a = OpW'(c_outer_q);   op_b = OpW'(x_q);          end
          3'd1: begin op_a = OpW'(c_middle_q);  op_b = OpW'(hist_q[0].x1); end
          3'd2: begin op_a = OpW'(c_outer_q);   op_b = OpW'(hist_q[0].x2); end
          3'd3: begin op_a = -OpW'(c_first_q);  op_b = OpW'(hist_q[0].y1); end
          3'd4: begin op_a = -OpW'(c_second_q); op_b = OpW'(hist_q[0].y2); end
          default: ;
        endcase
      end
      GRP_MIX_L, GRP_MIX_R: begin
        if (term_q == 3'd0) begin
          op_a = OpW'((grp_q == GRP_MIX_L) ? in_q.in_left : in_q.in_right);
          op_b = $signed({{(OpW - GainW){1'b0}}, dry});
        end else begin
          op_a = OpW'((grp_q == GRP_MIX_L) ? fl_q : fr_q);
          op_b = $signed({{(OpW - GainW){1'b0}}, wet_q});
        end
      end
      default: ;
    endcase
  end

  assign mac_ctl.clr        = (state_q == ST_ISSUE) && (term_q == 3'd0);
  assign mac_ctl.add        = (state_q == ST_ISSUE) && (term_q != 3'd0);
  assign mac_ctl.coef_shift = is_bq;

  ppdh_mac u_mac (
    .clk_i     (clk_i),
    .ctl_i     (mac_ctl),
    .op_a_i    (op_a),
    .op_b_i    (op_b),
    .shifted_o (mac_shifted),
    .sat_o     (mac_sat)
  );

  // Sequencer: each group issues its products, then takes the result in its finish state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grp_q       <= GRP_FB;
      term_q      <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      echo_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < 4; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            echo_ok_q <= full_q || (rp < wp_q);
            grp_q     <= GRP_FB;
            term_q    <= '0;
            state_q   <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (last_term) begin
            term_q  <= '0;
            state_q <= ST_FINISH;
          end else begin
            term_q <= term_q + 3'd1;
          end
        end
        ST_FINISH: begin
          state_q <= ST_ISSUE;
          case (grp_q)
            GRP_FB: begin
              if (wp_q == AW'(DELAY_DEPTH - 1)) begin
                wp_q   <= '0;
                full_q <= 1'b1;
              end else begin
                wp_q <= wp_q + AW'(1);
              end
              grp_q <= GRP_BQ0;
            end
            GRP_BQ0, GRP_BQ1, GRP_BQ2, GRP_BQ3: begin
              // The histories rotate so that the active stage always sits in slot zero.
              for (int i = 0; i < 3; i++) begin
                hist_q[i] <= hist_q[i+1];
              end
              hist_q[3] <= '{x1: x_q, x2: hist_q[0].x1, y1: mac_sat, y2: hist_q[0].y1};
              case (grp_q)
                GRP_BQ0: grp_q <= GRP_BQ1;
                GRP_BQ1: grp_q <= GRP_BQ2;
                GRP_BQ2: grp_q <= GRP_BQ3;
                default: grp_q <= GRP_MIX_L;
              endcase
            end
            GRP_MIX_L: grp_q <= GRP_MIX_R;
            GRP_MIX_R: begin
              if (!out_valid_q || !out_stall_i) begin
                out_q.out_left  <= mixl_q;
                out_q.out_right <= mac_sat;
                out_valid_q     <= 1'b1;
                state_q         <= ST_IDLE;
              end else begin
                state_q <= ST_FINISH;
              end
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Data registers of the item at work.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (state_q == ST_FINISH) begin
      case (grp_q)
        GRP_FB:    x_q <= echo_l;
        GRP_BQ0:   x_q <= mac_sat;
        GRP_BQ1: begin
          fl_q <= mac_sat;
          x_q  <= echo_r;
        end
        GRP_BQ2:   x_q <= mac_sat;
        GRP_BQ3:   fr_q <= mac_sat;
        GRP_MIX_L: mixl_q <= mac_sat;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ppdh_checker.sv -----
// Port-level checks of the ping-pong delay block and their binding to the top level.
`include "ping_pong_delay_hpf_defines.svh"

module ppdh_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input ppdh_pkg::in_t             in_data_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input ppdh_pkg::out_t            out_data_o,
  input logic                      cfg_we_i,
  input ppdh_pkg::cfg_idx_e        cfg_idx_i,
  input logic [ppdh_pkg::CfgW-1:0] cfg_wdata_i
);

  // An accepted item keeps the block busy in the following cycle.
  `PPDH_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  `PPDH_ASSERT_SAME(a_in_known, in_valid_i, !$isunknown(in_data_i))

  `PPDH_ASSERT_SAME(a_cfg_known, cfg_we_i, !$isunknown({cfg_idx_i, cfg_wdata_i}))

  `PPDH_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)

  `PPDH_ASSERT_NEXT(a_out_data_holds, out_valid_o && out_stall_i, $stable(out_data_o))

endmodule

bind ping_pong_delay_hpf ppdh_checker u_ppdh_checker (.*);
